// ===== rtl/utf_pkg.sv =====
package utf_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int IDX_W  = 2;
    localparam int UNIT_W = 16;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 10;

    localparam logic [5:0] HIGH_TAG = 6'b110110;
    localparam logic [5:0] LOW_TAG  = 6'b110111;

    localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // one request for the back end: up to two code points in output order
    typedef struct packed {
        logic [CP_W-1:0]  cp0;
        logic [LEN_W-1:0] len0;
        logic [CP_W-1:0]  cp1;
        logic [LEN_W-1:0] len1;
    } job_t;

    function automatic logic [LEN_W-1:0] cp_len(input logic [CP_W-1:0] cp);
        logic [LEN_W-1:0] n;
        if (cp <= 21'h00007F)
        begin
            n = LEN_ONE;
        end
        else if (cp <= 21'h0007FF)
        begin
            n = LEN_TWO;
        end
        else if (cp <= 21'h00FFFF)
        begin
            n = LEN_THREE;
        end
        else
        begin
            n = LEN_FOUR;
        end
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] enc_byte(
        input logic [CP_W-1:0]  cp,
        input logic [LEN_W-1:0] len,
        input logic [IDX_W-1:0] idx
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        unique case (len)
            LEN_ONE:
            begin
                b = {1'b0, cp[6:0]};
            end
            LEN_TWO:
            begin
                b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            LEN_THREE:
            begin
                unique case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                unique case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/utf16_to_utf8_encoder.sv =====
// path: a job is queued, then loaded into the back end, which registers its output bytes
// throughput: one unit per cycle in while the queue is not full, one byte per cycle out
//   while pop is held; a unit settles 0 to 6 bytes
// the byte emitter sets the sustained rate
// reset: asynchronous active-low rst_n empties the queue and output, drops the held surrogate
module utf16_to_utf8_encoder #(
    parameter int DEPTH = utf_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [utf_pkg::UNIT_W-1:0]   code_unit,
    input  logic                         pop,
    output logic                         empty,
    output logic [utf_pkg::BYTE_W-1:0]   out_byte,
    output logic                         last_of_run
);

    utf_pkg::job_t front_job;
    utf_pkg::job_t q_job;
    logic          job_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;

    utf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .code_unit (code_unit),
        .q_full    (q_full),
        .full      (full),
        .job_push  (job_push),
        .job       (front_job)
    );

    utf_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (front_job),
        .rd_en   (q_pop),
        .rd_data (q_job),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    utf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_job       (q_job),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// ===== rtl/utf_front.sv =====
module utf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [utf_pkg::UNIT_W-1:0]   code_unit,
    input  logic                         q_full,
    output logic                         full,
    output logic                         job_push,
    output utf_pkg::job_t                job
);

    logic                        pend_valid_reg;
    logic                        pend_valid_next;
    logic [utf_pkg::PEND_W-1:0]  pend_high_reg;
    logic [utf_pkg::PEND_W-1:0]  pend_high_next;
    logic                        accept;
    logic                        is_high;
    logic                        is_low;
    logic [utf_pkg::CP_W-1:0]    unit_cp;
    logic [utf_pkg::CP_W-1:0]    held_cp;
    logic [utf_pkg::CP_W-1:0]    pair_cp;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign is_high = (code_unit[15:10] == utf_pkg::HIGH_TAG);
    assign is_low  = (code_unit[15:10] == utf_pkg::LOW_TAG);
    assign unit_cp = {5'b0, code_unit};
    assign held_cp = {5'b0, utf_pkg::HIGH_TAG, pend_high_reg};
    assign pair_cp = {1'b0, pend_high_reg, code_unit[9:0]} + utf_pkg::SUPP_BASE;

    always_comb
    begin
        job.cp0  = unit_cp;
        job.len0 = utf_pkg::cp_len(unit_cp);
        job.cp1  = unit_cp;
        job.len1 = utf_pkg::LEN_NONE;
        job_push = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_high_next  = pend_high_reg;
        if (pend_valid_reg && is_low)
        begin
            job.cp0  = pair_cp;
            job.len0 = utf_pkg::LEN_FOUR;
        end
        else if (pend_valid_reg)
        begin
            job.cp0  = held_cp;
            job.len0 = utf_pkg::LEN_THREE;
            job.len1 = is_high ? utf_pkg::LEN_NONE : utf_pkg::cp_len(unit_cp);
        end
        if (accept)
        begin
            job_push        = pend_valid_reg || !is_high;
            pend_valid_next = is_high && !(pend_valid_reg && is_low);
            pend_high_next  = code_unit[9:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_high_reg  <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_high_reg  <= pend_high_next;
        end
    end

endmodule

// ===== rtl/utf_fifo.sv =====
module utf_fifo #(
    parameter int DEPTH = utf_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  utf_pkg::job_t wr_data,
    input  logic          rd_en,
    output utf_pkg::job_t rd_data,
    output logic          q_full,
    output logic          q_empty
);

    localparam int AW = $clog2(DEPTH);

    utf_pkg::job_t  mem [DEPTH];
    logic [AW:0]    wr_ptr_reg;
    logic [AW:0]    wr_ptr_next;
    logic [AW:0]    rd_ptr_reg;
    logic [AW:0]    rd_ptr_next;

    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW])
                  && (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign rd_data = mem[rd_ptr_reg[AW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en && !q_full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en && !q_empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !q_full)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

// ===== rtl/utf_back.sv =====
module utf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  utf_pkg::job_t                q_job,
    output logic                         q_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [utf_pkg::BYTE_W-1:0]   out_byte,
    output logic                         last_of_run
);

    utf_pkg::job_t               job_reg;
    logic                        job_valid_reg;
    logic                        job_valid_next;
    logic                        phase_reg;
    logic                        phase_next;
    logic [utf_pkg::IDX_W-1:0]   idx_reg;
    logic [utf_pkg::IDX_W-1:0]   idx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [utf_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                        last_reg;
    logic [utf_pkg::CP_W-1:0]    cur_cp;
    logic [utf_pkg::LEN_W-1:0]   cur_len;
    logic                        idx_end;
    logic                        job_end;
    logic                        advance;

    assign cur_cp  = phase_reg ? job_reg.cp1 : job_reg.cp0;
    assign cur_len = phase_reg ? job_reg.len1 : job_reg.len0;
    assign idx_end = ({1'b0, idx_reg} == (cur_len - 3'd1));
    assign job_end = idx_end && (phase_reg || (job_reg.len1 == utf_pkg::LEN_NONE));
    assign advance = job_valid_reg && (!out_valid_reg || pop);
    assign q_pop   = !q_empty && (!job_valid_reg || (advance && job_end));

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        if (q_pop)
        begin
            job_valid_next = 1'b1;
            phase_next     = 1'b0;
            idx_next       = '0;
        end
        else if (advance)
        begin
            if (job_end)
            begin
                job_valid_next = 1'b0;
            end
            else if (idx_end)
            begin
                phase_next = 1'b1;
                idx_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (advance)
        begin
            out_byte_reg <= utf_pkg::enc_byte(cur_cp, cur_len, idx_reg);
            last_reg     <= job_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/utf_checker.sv =====
module utf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pop,
    input logic                         empty,
    input logic [utf_pkg::BYTE_W-1:0]   out_byte,
    input logic                         last_of_run
);

    // nothing to pop while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("output not empty during reset");

    // a stalled byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)))
        else $error("stalled output changed");

    // single-byte sequences always close a request
    a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_byte[7]) |-> last_of_run)
        else $error("ascii byte not last of run");

    // a lead byte never closes a request
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_byte[7:6] == 2'b11) |-> !last_of_run)
        else $error("lead byte marked last");

    // a popped lead byte is followed at once by a continuation byte
    a_lead_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_byte[7:6] == 2'b11) |=> (!empty && out_byte[7:6] == 2'b10))
        else $error("missing continuation after lead byte");

endmodule

bind utf16_to_utf8_encoder utf_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);
